[rtl/core/rwhr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhr_pkg
// Shared types and constants of the ryb wheel hue rotation block.
// ----------------------------------------------------------------------------
package rwhr_pkg;

  // input pixel word
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rwhr_in_t;

  // output pixel word
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rwhr_out_t;

  // angle constants in whole degrees
  localparam int unsigned FULL_DEG  = 360;
  localparam int unsigned SIXTH_DEG = 60;
  localparam int unsigned SEG_SPAN  = 15;
  localparam int unsigned NUM_SEG   = 24;
  localparam logic [8:0]  ROT_RESET = 9'd180;

  // rgb hue at each wheel knot, the wheel angle of knot i is 15*i
  localparam logic [8:0] WHEEL_Y [0:24] = '{
    9'd0,   9'd8,   9'd17,  9'd26,  9'd34,  9'd41,  9'd48,  9'd54,  9'd60,
    9'd81,  9'd103, 9'd123, 9'd138, 9'd155, 9'd171, 9'd187, 9'd204, 9'd219,
    9'd234, 9'd251, 9'd267, 9'd282, 9'd298, 9'd329, 9'd360
  };

endpackage

[rtl/core/ryb_wheel_hue_rotation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryb_wheel_hue_rotation
// Rotates the hue of an rgb pixel on the red-yellow-blue artist wheel.
// Throughput: one word per cycle while the output is not stalled;
// the hue divider retires four quotient bits per stage and each later
// stage holds at most one multiplier.
// Reset clears all valid bits and sets the rotation to 180 degrees.
// ----------------------------------------------------------------------------
module ryb_wheel_hue_rotation
  import rwhr_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  rwhr_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rwhr_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);

  localparam int F      = HUE_FRAC_BITS;
  localparam int HW     = F + 9;
  localparam int NW     = F + 17;
  localparam int DS     = (NW + 3) / 4;
  localparam int NWP    = DS * 4;
  localparam int NS     = DS + 12;
  localparam int OFF_FW = F + 5;
  localparam int NUM_FW = F + 9;
  localparam int KF     = F + 14;
  localparam int RF_W   = F + 12;
  localparam int PF_W   = NUM_FW + RF_W;
  localparam int OFF_RW = F + 4;
  localparam int NUM_RW = F + 9;
  localparam int KR     = F + 13;
  localparam int RR_W   = F + 10;
  localparam int PR_W   = NUM_RW + RR_W;
  localparam longint unsigned RR_V = ((64'd1 << KR) + 64'd14) / 64'd15;
  localparam int RM_W   = F + 6;
  localparam int BP_W   = RM_W + 8;
  localparam int KB     = 20;
  localparam int UP_W   = 29;
  localparam longint unsigned RB_V = ((64'd1 << KB) + 64'd59) / 64'd60;

  localparam logic [HW:0] FULL_FX = (HW+1)'(FULL_DEG) << F;

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP, SEC_RED_DOWN, SEC_BLUE_UP, SEC_GREEN_DOWN,
    SEC_RED_UP, SEC_BLUE_DOWN
  } sec_e;

  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic       gray;
  } pix_t;

  typedef struct packed {
    pix_t        pix;
    logic [16:0] num;
  } front_t;

  typedef struct packed {
    pix_t           pix;
    logic [16:0]    num;
    logic [7:0]     rem;
    logic [NWP-1:0] quo;
  } div_t;

  typedef struct packed {
    pix_t              pix;
    logic [4:0]        seg;
    logic [OFF_FW-1:0] off;
  } fm1_t;

  typedef struct packed {
    pix_t            pix;
    logic [4:0]      seg;
    logic [PF_W-1:0] prod;
  } fm2_t;

  typedef struct packed {
    pix_t          pix;
    logic [HW-1:0] ang;
  } ang_t;

  typedef struct packed {
    pix_t              pix;
    logic [4:0]        seg;
    logic [OFF_RW-1:0] off;
  } rm1_t;

  typedef struct packed {
    pix_t              pix;
    logic [4:0]        seg;
    logic [NUM_RW-1:0] num;
  } rm2_t;

  typedef struct packed {
    pix_t            pix;
    logic [4:0]      seg;
    logic [PR_W-1:0] prod;
  } rm3_t;

  typedef struct packed {
    pix_t            pix;
    sec_e            sec;
    logic [RM_W-1:0] rm;
  } r1_t;

  typedef struct packed {
    pix_t            pix;
    sec_e            sec;
    logic [BP_W-1:0] bp;
  } r2_t;

  typedef struct packed {
    pix_t            pix;
    sec_e            sec;
    logic [BP_W-1:0] bp;
    logic [7:0]      up;
  } r3_t;

  // segment slopes and reciprocals
  logic [4:0]      seg_dy    [NUM_SEG];
  logic [RF_W-1:0] fwd_recip [NUM_SEG];

  for (genvar i = 0; i < NUM_SEG; i++) begin : g_seg
    localparam longint unsigned DY = longint'(WHEEL_Y[i+1]) - longint'(WHEEL_Y[i]);
    localparam longint unsigned RV = ((64'd1 << KF) + DY - 64'd1) / DY;
    assign seg_dy[i]    = 5'(DY);
    assign fwd_recip[i] = RF_W'(RV);
  end

  // rotation register
  logic [8:0] rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_RESET;
    end else if (cfg_we_i) begin
      rot_q <= cfg_wdata_i;
    end
  end

  // stage enables, a stage moves when empty or when the next one moves
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // front: extremes, chroma and hue numerator
  front_t front_d, front_q;

  always_comb begin
    logic [7:0] r, g, b, mx, mn, d;
    logic [16:0] d17;
    r   = in_data_i.red_in;
    g   = in_data_i.green_in;
    b   = in_data_i.blue_in;
    mx  = (r > g) ? r : g;
    mx  = (b > mx) ? b : mx;
    mn  = (r < g) ? r : g;
    mn  = (b < mn) ? b : mn;
    d   = mx - mn;
    d17 = 17'(d);
    if (r == mx) begin
      if (g >= b) begin
        front_d.num = 17'(g - b) * 17'd60;
      end else begin
        front_d.num = d17 * 17'd360 - 17'(b - g) * 17'd60;
      end
    end else if (g == mx) begin
      if (b >= r) begin
        front_d.num = d17 * 17'd120 + 17'(b - r) * 17'd60;
      end else begin
        front_d.num = d17 * 17'd120 - 17'(r - b) * 17'd60;
      end
    end else begin
      if (r >= g) begin
        front_d.num = d17 * 17'd240 + 17'(r - g) * 17'd60;
      end else begin
        front_d.num = d17 * 17'd240 - 17'(g - r) * 17'd60;
      end
    end
    front_d.pix.mx   = mx;
    front_d.pix.mn   = mn;
    front_d.pix.d    = d;
    front_d.pix.gray = (d == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_q <= front_d;
    end
  end

  // hue divider, four quotient bits per stage
  div_t div_src [DS];
  div_t div_d   [DS];
  div_t div_q   [DS];

  for (genvar s = 0; s < DS; s++) begin : g_div
    if (s == 0) begin : g_first
      assign div_src[s] = '{pix: front_q.pix, num: front_q.num, rem: '0, quo: '0};
    end else begin : g_next
      assign div_src[s] = div_q[s-1];
    end

    always_comb begin
      logic [NWP-1:0] dvd;
      logic [8:0]     r9;
      logic [7:0]     rem;
      logic [NWP-1:0] quo;
      dvd = NWP'(div_src[s].num) << F;
      rem = div_src[s].rem;
      quo = div_src[s].quo;
      for (int t = 0; t < 4; t++) begin
        r9 = {rem, dvd[NWP-1-4*s-t]};
        if (r9 >= {1'b0, div_src[s].pix.d}) begin
          rem = 8'(r9 - {1'b0, div_src[s].pix.d});
          quo = {quo[NWP-2:0], 1'b1};
        end else begin
          rem = r9[7:0];
          quo = {quo[NWP-2:0], 1'b0};
        end
      end
      div_d[s]     = div_src[s];
      div_d[s].rem = rem;
      div_d[s].quo = quo;
    end

    always_ff @(posedge clk_i) begin
      if (en[s+1]) begin
        div_q[s] <= div_d[s];
      end
    end
  end

  // forward map, segment search
  fm1_t fm1_d, fm1_q;

  always_comb begin
    logic [HW-1:0] h;
    logic [4:0]    seg;
    h   = div_q[DS-1].quo[HW-1:0];
    seg = '0;
    for (int k = 1; k < NUM_SEG; k++) begin
      if (h >= (HW'(WHEEL_Y[k]) << F)) begin
        seg = 5'(k);
      end
    end
    fm1_d.pix = div_q[DS-1].pix;
    fm1_d.seg = seg;
    fm1_d.off = OFF_FW'(h - (HW'(WHEEL_Y[seg]) << F));
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+1]) begin
      fm1_q <= fm1_d;
    end
  end

  // forward map, scale by 15 and divide by the segment rise
  fm2_t fm2_d, fm2_q;

  always_comb begin
    logic [NUM_FW-1:0] n;
    n = (NUM_FW'(fm1_q.off) << 4) - NUM_FW'(fm1_q.off);
    fm2_d.pix  = fm1_q.pix;
    fm2_d.seg  = fm1_q.seg;
    fm2_d.prod = PF_W'(n) * PF_W'(fwd_recip[fm1_q.seg]);
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+2]) begin
      fm2_q <= fm2_d;
    end
  end

  // wheel angle plus rotation, modulo a full turn
  ang_t fm3_d, fm3_q;

  always_comb begin
    logic [8:0]  rot;
    logic [HW:0] a;
    rot = (rot_q >= 9'(FULL_DEG)) ? rot_q - 9'(FULL_DEG) : rot_q;
    a   = ((HW+1)'(fm2_q.seg) * (HW+1)'(SEG_SPAN) << F)
        + (HW+1)'(fm2_q.prod[KF +: F+4])
        + ((HW+1)'(rot) << F);
    if (a >= FULL_FX) begin
      a = a - FULL_FX;
    end
    fm3_d.pix = fm2_q.pix;
    fm3_d.ang = a[HW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+3]) begin
      fm3_q <= fm3_d;
    end
  end

  // reverse map, segment search on the even wheel spacing
  rm1_t rm1_d, rm1_q;

  always_comb begin
    logic [4:0] seg;
    seg = '0;
    for (int k = 1; k < NUM_SEG; k++) begin
      if (fm3_q.ang >= (HW'(k * SEG_SPAN) << F)) begin
        seg = 5'(k);
      end
    end
    rm1_d.pix = fm3_q.pix;
    rm1_d.seg = seg;
    rm1_d.off = OFF_RW'(fm3_q.ang - (HW'(seg) * HW'(SEG_SPAN) << F));
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+4]) begin
      rm1_q <= rm1_d;
    end
  end

  // reverse map, scale by the segment rise
  rm2_t rm2_d, rm2_q;

  always_comb begin
    rm2_d.pix = rm1_q.pix;
    rm2_d.seg = rm1_q.seg;
    rm2_d.num = NUM_RW'(seg_dy[rm1_q.seg]) * NUM_RW'(rm1_q.off);
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+5]) begin
      rm2_q <= rm2_d;
    end
  end

  // reverse map, divide by 15
  rm3_t rm3_d, rm3_q;

  always_comb begin
    rm3_d.pix  = rm2_q.pix;
    rm3_d.seg  = rm2_q.seg;
    rm3_d.prod = PR_W'(rm2_q.num) * PR_W'(RR_V);
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+6]) begin
      rm3_q <= rm3_d;
    end
  end

  // rgb hue back from the segment knot
  ang_t rm4_d, rm4_q;

  always_comb begin
    logic [HW:0] h;
    h = ((HW+1)'(WHEEL_Y[rm3_q.seg]) << F) + (HW+1)'(rm3_q.prod[KR +: F+5]);
    if (h >= FULL_FX) begin
      h = h - FULL_FX;
    end
    rm4_d.pix = rm3_q.pix;
    rm4_d.ang = h[HW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+7]) begin
      rm4_q <= rm4_d;
    end
  end

  // rebuild, sector and remainder
  r1_t r1_d, r1_q;

  always_comb begin
    sec_e sec;
    sec = SEC_RED_GREEN_UP;
    for (int k = 1; k < 6; k++) begin
      if (rm4_q.ang >= (HW'(k * SIXTH_DEG) << F)) begin
        sec = sec_e'(3'(k));
      end
    end
    r1_d.pix = rm4_q.pix;
    r1_d.sec = sec;
    r1_d.rm  = RM_W'(rm4_q.ang - (HW'(sec) * HW'(SIXTH_DEG) << F));
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+8]) begin
      r1_q <= r1_d;
    end
  end

  // rebuild, chroma times remainder
  r2_t r2_d, r2_q;

  always_comb begin
    r2_d.pix = r1_q.pix;
    r2_d.sec = r1_q.sec;
    r2_d.bp  = BP_W'(r1_q.pix.d) * BP_W'(r1_q.rm);
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+9]) begin
      r2_q <= r2_d;
    end
  end

  // rebuild, divide by one sixth of a turn
  r3_t r3_d, r3_q;

  always_comb begin
    logic [UP_W-1:0] upp;
    upp = UP_W'(r2_q.bp >> F) * UP_W'(RB_V);
    r3_d.pix = r2_q.pix;
    r3_d.sec = r2_q.sec;
    r3_d.bp  = r2_q.bp;
    r3_d.up  = upp[KB +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (en[DS+10]) begin
      r3_q <= r3_d;
    end
  end

  // rebuild, channel select into the output register
  rwhr_out_t out_d, out_q;

  always_comb begin
    logic       exact;
    logic [7:0] dn, rise, fall, mx, mn;
    mx    = r3_q.pix.mx;
    mn    = r3_q.pix.mn;
    exact = (r3_q.bp == (BP_W'(r3_q.up) * BP_W'(SIXTH_DEG) << F));
    dn    = r3_q.up + 8'(!exact);
    rise  = mn + r3_q.up;
    fall  = mx - dn;
    case (r3_q.sec)
      SEC_RED_GREEN_UP: out_d = '{red_out: mx,   green_out: rise, blue_out: mn};
      SEC_RED_DOWN:     out_d = '{red_out: fall, green_out: mx,   blue_out: mn};
      SEC_BLUE_UP:      out_d = '{red_out: mn,   green_out: mx,   blue_out: rise};
      SEC_GREEN_DOWN:   out_d = '{red_out: mn,   green_out: fall, blue_out: mx};
      SEC_RED_UP:       out_d = '{red_out: rise, green_out: mn,   blue_out: mx};
      default:          out_d = '{red_out: mx,   green_out: mn,   blue_out: fall};
    endcase
    if (r3_q.pix.gray) begin
      out_d = '{red_out: mx, green_out: mx, blue_out: mx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[tb/ryb_wheel_hue_rotation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryb_wheel_hue_rotation_tb
// Streams rgb pixels through the ryb wheel hue rotation block and checks
// every output word against a fixed-point model of the hue rotation, over
// several rotation settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module ryb_wheel_hue_rotation_tb;
  import rwhr_pkg::*;

  localparam int FRAC      = 8;
  localparam int LATENCY   = (FRAC + 20) / 4 + 12;
  localparam int MAX_CYCLE = 400000;
  localparam int NUM_PHASE = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  rwhr_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rwhr_out_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = 9'd0;

  // model state and stores
  logic [8:0] model_rotation = ROT_RESET;
  rwhr_in_t   pixel_queue [$];
  rwhr_out_t  rotated_queue [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         long_hold = 0;
  bit         driver_hold = 1'b1;
  int         burst_left = 0;
  int         gap_left = 0;

  ryb_wheel_hue_rotation #(.HUE_FRAC_BITS(FRAC)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // wheel angle of knot i
  function automatic longint knot_x(int i);
    return longint'(SEG_SPAN) * i;
  endfunction

  // rgb hue to wheel angle, first matching segment wins
  function automatic longint hue_to_wheel(longint h);
    longint lo, hi;
    for (int i = 0; i < NUM_SEG; i++) begin
      lo = longint'(WHEEL_Y[i]) << FRAC;
      hi = longint'(WHEEL_Y[i+1]) << FRAC;
      if (lo <= h && h <= hi)
        return (knot_x(i) << FRAC) + (SEG_SPAN * (h - lo)) / (WHEEL_Y[i+1] - WHEEL_Y[i]);
    end
    return 0;
  endfunction

  // wheel angle back to rgb hue
  function automatic longint wheel_to_hue(longint a);
    longint lo, hi;
    for (int i = 0; i < NUM_SEG; i++) begin
      lo = knot_x(i) << FRAC;
      hi = knot_x(i + 1) << FRAC;
      if (lo <= a && a <= hi)
        return (longint'(WHEEL_Y[i]) << FRAC)
             + (longint'(WHEEL_Y[i+1] - WHEEL_Y[i]) * (a - lo)) / SEG_SPAN;
    end
    return 0;
  endfunction

  function automatic rwhr_out_t rotate_pixel(rwhr_in_t p, logic [8:0] rot);
    longint r, g, b, mx, mn, d, num, h, a, full, sixth, sec, rm, prod, up, dn;
    longint rise, fall;
    rwhr_out_t o;
    r = p.red_in; g = p.green_in; b = p.blue_in;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // grey pixel keeps its level
    if (d == 0) begin
      o.red_out = mx[7:0]; o.green_out = mx[7:0]; o.blue_out = mx[7:0];
      return o;
    end
    if (r == mx) num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
    else if (g == mx) num = 120 * d + 60 * (b - r);
    else num = 240 * d + 60 * (r - g);
    h = (num << FRAC) / d;
    full = longint'(FULL_DEG) << FRAC;
    a = hue_to_wheel(h) + (longint'(rot % FULL_DEG) << FRAC);
    if (a >= full) a -= full;
    h = wheel_to_hue(a);
    if (h >= full) h -= full;
    sixth = longint'(SIXTH_DEG) << FRAC;
    sec = h / sixth;
    rm = h % sixth;
    prod = d * rm;
    up = prod / sixth;
    dn = up + ((prod % sixth) != 0);
    rise = mn + up;
    fall = mx - dn;
    case (sec)
      0: o = {mx[7:0], rise[7:0], mn[7:0]};
      1: o = {fall[7:0], mx[7:0], mn[7:0]};
      2: o = {mn[7:0], mx[7:0], rise[7:0]};
      3: o = {mn[7:0], fall[7:0], mx[7:0]};
      4: o = {rise[7:0], mn[7:0], mx[7:0]};
      default: o = {mx[7:0], mn[7:0], fall[7:0]};
    endcase
    return o;
  endfunction

  function automatic rwhr_in_t random_pixel();
    rwhr_in_t p;
    int lvl;
    p = 24'($urandom());
    case ($urandom_range(0, 7))
      0: begin
        lvl = $urandom_range(0, 255);
        p = {lvl[7:0], lvl[7:0], lvl[7:0]};
      end
      1: p.red_in = p.green_in;
      2: p.blue_in = p.red_in;
      default: ;
    endcase
    return p;
  endfunction

  // append one pixel to the pending words
  task automatic queue_pixel(rwhr_in_t p);
    pixel_queue = {pixel_queue, p};
  endtask

  // driver: bursts with random gaps, model run on acceptance
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rotated_queue = {rotated_queue, rotate_pixel(in_data_i, model_rotation)};
        void'(pixel_queue.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!driver_hold && pixel_queue.size() > 0 &&
                     !(in_valid_i && !in_stall_o && pixel_queue.size() == 0)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pixel_queue[0];
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall_i <= 1'b1;
    end else if (cycle_count % 2000 < 600) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // monitor: compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    rwhr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rotated_queue.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected word %h", out_data_o);
      end else begin
        want = rotated_queue.pop_front();
        if (want !== out_data_o) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected r %h g %h b %h, got r %h g %h b %h",
                     want.red_out, want.green_out, want.blue_out,
                     out_data_o.red_out, out_data_o.green_out, out_data_o.blue_out);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid_i || rotated_queue.size() > 0)
      @(posedge clk_i);
    driver_hold = 1'b1;
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_rotation(logic [8:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    model_rotation = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  logic [8:0] phase_rot [NUM_PHASE] = '{9'd0, 9'd359, 9'd360, 9'd511, 9'd90, 9'd180};

  initial begin
    logic [8:0] rot;
    rwhr_in_t p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed words at the reset rotation
    queue_pixel({8'h00, 8'h00, 8'h00});
    queue_pixel({8'hff, 8'hff, 8'hff});
    queue_pixel({8'h80, 8'h80, 8'h80});
    queue_pixel({8'hff, 8'h00, 8'h00});
    queue_pixel({8'h00, 8'hff, 8'h00});
    queue_pixel({8'h00, 8'h00, 8'hff});
    queue_pixel({8'hff, 8'hff, 8'h00});
    queue_pixel({8'h00, 8'hff, 8'hff});
    queue_pixel({8'hff, 8'h00, 8'hff});
    queue_pixel({8'hff, 8'h00, 8'h01});
    queue_pixel({8'h01, 8'h00, 8'h00});
    queue_pixel({8'hfe, 8'hff, 8'h01});
    queue_pixel({8'h55, 8'haa, 8'h00});
    driver_hold = 1'b0;
    wait_drained();
    for (int ph = 0; ph < NUM_PHASE; ph++) begin
      rot = phase_rot[ph];
      write_rotation(rot);
      for (int k = 0; k < 300; k++) begin
        p = random_pixel();
        queue_pixel(p);
      end
      driver_hold = 1'b0;
      // long output hold-off so the pipe fills and stalls its input
      if (ph == 1) long_hold = 200;
      wait_drained();
    end
    for (int k = 0; k < 150; k++) queue_pixel(random_pixel());
    write_rotation(9'($urandom_range(0, 511)));
    driver_hold = 1'b0;
    wait_drained();
    if (mismatch_count == 0 && rotated_queue.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
